@@ sv/gdpfs_pkg.sv @@
// Package for grid_disc_pairwise_force_sum: widths, register codes, state type
// and the one-bit long-division step shared by the x and y divider pipelines.
// No dependencies.
package gdpfs_pkg;

    localparam int GRID_SIZE = 64;
    localparam int IDX_W     = $clog2(GRID_SIZE);
    localparam int CRD_W     = IDX_W + 1;          // centred coordinate / difference
    localparam int CNT_W     = 2 * IDX_W;          // source cell counter
    localparam int RR_W      = 2 * IDX_W;          // radius squared
    localparam int RSQ_W     = 2 * IDX_W + 1;      // dx^2 + dy^2
    localparam int FRAC_W    = 20;
    localparam int QW        = FRAC_W + 1;         // quotient bits, one divider stage each
    localparam int TERM_W    = QW + 1;
    localparam int ACC_W     = CNT_W + FRAC_W + 2;
    localparam int RAD_W     = 6;
    localparam int GAIN_W    = 32;
    localparam int OUT_W     = 32;
    localparam int MAG_W     = 32;
    localparam int PROD_W    = MAG_W + GAIN_W;
    localparam int GAIN_FRAC = 16;
    localparam int CFG_IDX_W = 1;
    localparam int CFG_DAT_W = 32;

    localparam logic [CFG_IDX_W-1:0] REG_DISC_RADIUS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FORCE_GAIN  = 1'd1;

    localparam logic [RAD_W-1:0]  RADIUS_RST = RAD_W'(16);
    localparam logic [GAIN_W-1:0] GAIN_RST   = GAIN_W'(65536);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RUN,
        ST_DRAIN,
        ST_MAG,
        ST_MUL,
        ST_SAT
    } state_t;

    // one restoring division step: returns {quotient bit, new remainder}
    function automatic logic [RSQ_W:0] div_step(
        input logic [RSQ_W-1:0] rem,
        input logic             din,
        input logic [RSQ_W-1:0] dsr
    );
        logic [RSQ_W:0] t;
        logic [RSQ_W:0] diff;
        logic           ge;
        t    = {rem, din};
        diff = t - {1'b0, dsr};
        ge   = (t >= {1'b0, dsr});
        return ge ? {1'b1, diff[RSQ_W-1:0]} : {1'b0, t[RSQ_W-1:0]};
    endfunction

endpackage

@@ sv/grid_disc_pairwise_force_sum.sv @@
// Top level of grid_disc_pairwise_force_sum: source cell walker, term
// pipeline with two pipelined dividers, accumulators, gain scaling and output.
// Depends on gdpfs_pkg.
//
// Usage:
//   Query channel (in_valid/in_ready, query_row, query_col) takes one grid
//   cell. The block walks all GRID_SIZE*GRID_SIZE source cells, one per
//   cycle, through a term pipeline: centring and disc test, squared
//   distance, then a 21-stage divider (one quotient bit per stage) for each
//   of the x and y terms, then the accumulators. The walk over the source
//   cells sets how long one query takes; the pipeline drain and the scaling
//   states ST_MAG, ST_MUL and ST_SAT follow it. Only one query is worked on
//   at a time: in_ready is high while the engine idles.
//   Result channel (out_valid/out_ready, force_x, force_y, inside_body) is a
//   single output register. A finished result sits there until taken; the
//   next query is accepted meanwhile, and the engine waits in its last
//   state only if a new result is ready while the old one is still held.
//   Configuration (cfg_we, cfg_index, cfg_data) writes disc_radius or
//   force_gain; write only while idle.
//   Reset (rst_n low, asynchronous) empties the pipeline and the output
//   register and loads radius 16 and gain 1.0.
module grid_disc_pairwise_force_sum (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [gdpfs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [gdpfs_pkg::CFG_DAT_W-1:0]     cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [gdpfs_pkg::IDX_W-1:0]         query_row,
    input  logic [gdpfs_pkg::IDX_W-1:0]         query_col,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [gdpfs_pkg::OUT_W-1:0]  force_x,
    output logic signed [gdpfs_pkg::OUT_W-1:0]  force_y,
    output logic                                inside_body
);

    localparam int IDX_W  = gdpfs_pkg::IDX_W;
    localparam int CRD_W  = gdpfs_pkg::CRD_W;
    localparam int CNT_W  = gdpfs_pkg::CNT_W;
    localparam int RR_W   = gdpfs_pkg::RR_W;
    localparam int RSQ_W  = gdpfs_pkg::RSQ_W;
    localparam int QW     = gdpfs_pkg::QW;
    localparam int TERM_W = gdpfs_pkg::TERM_W;
    localparam int ACC_W  = gdpfs_pkg::ACC_W;
    localparam int MAG_W  = gdpfs_pkg::MAG_W;
    localparam int PROD_W = gdpfs_pkg::PROD_W;
    localparam int OUT_W  = gdpfs_pkg::OUT_W;
    localparam int GFRAC  = gdpfs_pkg::GAIN_FRAC;
    localparam int P_W    = PROD_W - GFRAC;

    localparam logic signed [CRD_W-1:0] HALF = CRD_W'(gdpfs_pkg::GRID_SIZE / 2);
    localparam logic [CNT_W-1:0] CNT_LAST = {CNT_W{1'b1}};
    localparam logic [P_W-1:0] POS_MAX = P_W'(64'h7FFF_FFFF);
    localparam logic [P_W-1:0] NEG_MAX = P_W'(64'h8000_0000);

    // ---------------- configuration ----------------
    logic [gdpfs_pkg::RAD_W-1:0]  radius_reg;
    logic [gdpfs_pkg::GAIN_W-1:0] gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= gdpfs_pkg::RADIUS_RST;
            gain_reg   <= gdpfs_pkg::GAIN_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                gdpfs_pkg::REG_DISC_RADIUS: radius_reg <= cfg_data[gdpfs_pkg::RAD_W-1:0];
                gdpfs_pkg::REG_FORCE_GAIN:  gain_reg   <= cfg_data[gdpfs_pkg::GAIN_W-1:0];
                default: ;
            endcase
        end
    end

    logic [RR_W-1:0] rr;
    assign rr = RR_W'(radius_reg * radius_reg);

    // ---------------- control ----------------
    gdpfs_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg;
    logic             pipe_busy;
    logic             in_acc;
    logic             out_load;
    logic             out_free;

    assign in_acc   = in_valid && in_ready;
    assign out_free = !out_valid || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            gdpfs_pkg::ST_IDLE:  if (in_valid) state_next = gdpfs_pkg::ST_RUN;
            gdpfs_pkg::ST_RUN:   if (cnt_reg == CNT_LAST) state_next = gdpfs_pkg::ST_DRAIN;
            gdpfs_pkg::ST_DRAIN: if (!pipe_busy) state_next = gdpfs_pkg::ST_MAG;
            gdpfs_pkg::ST_MAG:   state_next = gdpfs_pkg::ST_MUL;
            gdpfs_pkg::ST_MUL:   state_next = gdpfs_pkg::ST_SAT;
            gdpfs_pkg::ST_SAT:   if (out_free) state_next = gdpfs_pkg::ST_IDLE;
            default:             state_next = gdpfs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready = (state_reg == gdpfs_pkg::ST_IDLE);
        out_load = (state_reg == gdpfs_pkg::ST_SAT) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gdpfs_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (in_acc)
                cnt_reg <= '0;
            else if (state_reg == gdpfs_pkg::ST_RUN)
                cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // query, centred
    logic signed [CRD_W-1:0] qr_reg, qc_reg;

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            qr_reg <= $signed({1'b0, query_row}) - HALF;
            qc_reg <= $signed({1'b0, query_col}) - HALF;
        end
    end

    // ---------------- stage A: centring, disc test, differences ----------------
    logic signed [CRD_W-1:0] u, v;
    logic [RSQ_W-1:0]        uv_sq;
    logic                    a_vld_reg;
    logic                    a_in_reg;
    logic signed [CRD_W-1:0] a_dx_reg, a_dy_reg;

    always_comb
    begin
        u     = $signed({1'b0, cnt_reg[CNT_W-1:IDX_W]}) - HALF;
        v     = $signed({1'b0, cnt_reg[IDX_W-1:0]}) - HALF;
        uv_sq = RSQ_W'(u * u) + RSQ_W'(v * v);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_vld_reg <= 1'b0;
        else
            a_vld_reg <= (state_reg == gdpfs_pkg::ST_RUN);
    end

    always_ff @(posedge clk)
    begin
        a_in_reg <= (uv_sq <= {1'b0, rr});
        a_dx_reg <= qr_reg - u;
        a_dy_reg <= qc_reg - v;
    end

    // ---------------- stage B: magnitudes and squared distance ----------------
    logic [IDX_W-1:0] ax, ay;
    logic [RSQ_W-1:0] rsq;
    logic             b_vld_reg, b_ok_reg, b_sx_reg, b_sy_reg;
    logic [IDX_W-1:0] b_ax_reg, b_ay_reg;
    logic [RSQ_W-1:0] b_rsq_reg;

    always_comb
    begin
        ax  = a_dx_reg[CRD_W-1] ? IDX_W'(-a_dx_reg) : a_dx_reg[IDX_W-1:0];
        ay  = a_dy_reg[CRD_W-1] ? IDX_W'(-a_dy_reg) : a_dy_reg[IDX_W-1:0];
        rsq = RSQ_W'(ax * ax) + RSQ_W'(ay * ay);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            b_vld_reg <= 1'b0;
        else
            b_vld_reg <= a_vld_reg;
    end

    always_ff @(posedge clk)
    begin
        b_ok_reg  <= a_in_reg && (rsq != '0);
        b_sx_reg  <= a_dx_reg[CRD_W-1];
        b_sy_reg  <= a_dy_reg[CRD_W-1];
        b_ax_reg  <= ax;
        b_ay_reg  <= ay;
        b_rsq_reg <= rsq;
    end

    // ---------------- divider pipeline: one quotient bit per stage ----------------
    // dividend is |d| << 20; |d| >> 1 is below the divisor, so the
    // first stage starts from |d| >> 1 and shifts in |d|[0], later stages zeros.
    logic             dv_vld_reg [QW];
    logic             dv_ok_reg  [QW];
    logic             dv_sx_reg  [QW];
    logic             dv_sy_reg  [QW];
    logic [RSQ_W-1:0] dv_d_reg   [QW];
    logic [RSQ_W-1:0] dv_rx_reg  [QW];
    logic [RSQ_W-1:0] dv_ry_reg  [QW];
    logic [QW-1:0]    dv_qx_reg  [QW];
    logic [QW-1:0]    dv_qy_reg  [QW];
    logic [QW-1:0]    vld_vec;

    genvar k;
    generate
        for (k = 0; k < QW; k++)
        begin : g_div
            logic             vld_in, ok_in, sx_in, sy_in, bx_in, by_in;
            logic [RSQ_W-1:0] d_in, rx_in, ry_in;
            logic [QW-1:0]    qx_in, qy_in;
            logic [RSQ_W:0]   stx, sty;

            if (k == 0)
            begin : g_first
                assign vld_in = b_vld_reg;
                assign ok_in  = b_ok_reg;
                assign sx_in  = b_sx_reg;
                assign sy_in  = b_sy_reg;
                assign d_in   = b_rsq_reg;
                assign rx_in  = RSQ_W'(b_ax_reg[IDX_W-1:1]);
                assign ry_in  = RSQ_W'(b_ay_reg[IDX_W-1:1]);
                assign bx_in  = b_ax_reg[0];
                assign by_in  = b_ay_reg[0];
                assign qx_in  = '0;
                assign qy_in  = '0;
            end
            else
            begin : g_next
                assign vld_in = dv_vld_reg[k-1];
                assign ok_in  = dv_ok_reg[k-1];
                assign sx_in  = dv_sx_reg[k-1];
                assign sy_in  = dv_sy_reg[k-1];
                assign d_in   = dv_d_reg[k-1];
                assign rx_in  = dv_rx_reg[k-1];
                assign ry_in  = dv_ry_reg[k-1];
                assign bx_in  = 1'b0;
                assign by_in  = 1'b0;
                assign qx_in  = dv_qx_reg[k-1];
                assign qy_in  = dv_qy_reg[k-1];
            end

            assign stx = gdpfs_pkg::div_step(rx_in, bx_in, d_in);
            assign sty = gdpfs_pkg::div_step(ry_in, by_in, d_in);

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_vld_reg[k] <= 1'b0;
                else
                    dv_vld_reg[k] <= vld_in;
            end

            always_ff @(posedge clk)
            begin
                dv_ok_reg[k] <= ok_in;
                dv_sx_reg[k] <= sx_in;
                dv_sy_reg[k] <= sy_in;
                dv_d_reg[k]  <= d_in;
                dv_rx_reg[k] <= stx[RSQ_W-1:0];
                dv_ry_reg[k] <= sty[RSQ_W-1:0];
                dv_qx_reg[k] <= {qx_in[QW-2:0], stx[RSQ_W]};
                dv_qy_reg[k] <= {qy_in[QW-2:0], sty[RSQ_W]};
            end

            assign vld_vec[k] = dv_vld_reg[k];
        end
    endgenerate

    assign pipe_busy = a_vld_reg || b_vld_reg || (|vld_vec);

    // ---------------- accumulation ----------------
    logic signed [TERM_W-1:0] tx, ty;
    logic signed [ACC_W-1:0]  acc_x_reg, acc_y_reg;

    always_comb
    begin
        tx = $signed({1'b0, dv_qx_reg[QW-1]});
        ty = $signed({1'b0, dv_qy_reg[QW-1]});
        if (dv_sx_reg[QW-1])
            tx = -tx;
        if (dv_sy_reg[QW-1])
            ty = -ty;
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            acc_x_reg <= '0;
            acc_y_reg <= '0;
        end
        else if (dv_vld_reg[QW-1] && dv_ok_reg[QW-1])
        begin
            acc_x_reg <= acc_x_reg + ACC_W'(tx);
            acc_y_reg <= acc_y_reg + ACC_W'(ty);
        end
    end

    // ---------------- scaling and saturation ----------------
    logic [ACC_W-1:0]  abs_x, abs_y;
    logic [MAG_W-1:0]  mag_x_reg, mag_y_reg;
    logic              neg_x_reg, neg_y_reg;
    logic              inside_reg;
    logic [PROD_W-1:0] prod_x_reg, prod_y_reg;
    logic [P_W-1:0]    px, py;
    logic [OUT_W-1:0]  res_x, res_y;

    always_comb
    begin
        abs_x = acc_x_reg[ACC_W-1] ? ACC_W'(-acc_x_reg) : ACC_W'(acc_x_reg);
        abs_y = acc_y_reg[ACC_W-1] ? ACC_W'(-acc_y_reg) : ACC_W'(acc_y_reg);
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == gdpfs_pkg::ST_MAG)
        begin
            neg_x_reg  <= acc_x_reg[ACC_W-1];
            neg_y_reg  <= acc_y_reg[ACC_W-1];
            mag_x_reg  <= (|abs_x[ACC_W-1:MAG_W]) ? {MAG_W{1'b1}} : abs_x[MAG_W-1:0];
            mag_y_reg  <= (|abs_y[ACC_W-1:MAG_W]) ? {MAG_W{1'b1}} : abs_y[MAG_W-1:0];
            inside_reg <= (RSQ_W'(qr_reg * qr_reg) + RSQ_W'(qc_reg * qc_reg))
                          <= {1'b0, rr};
        end
        if (state_reg == gdpfs_pkg::ST_MUL)
        begin
            prod_x_reg <= mag_x_reg * gain_reg;
            prod_y_reg <= mag_y_reg * gain_reg;
        end
    end

    always_comb
    begin
        px = prod_x_reg[PROD_W-1:GFRAC];
        py = prod_y_reg[PROD_W-1:GFRAC];
        if (neg_x_reg)
            res_x = (px > NEG_MAX) ? OUT_W'(-NEG_MAX) : OUT_W'(-px);
        else
            res_x = (px > POS_MAX) ? POS_MAX[OUT_W-1:0] : px[OUT_W-1:0];
        if (neg_y_reg)
            res_y = (py > NEG_MAX) ? OUT_W'(-NEG_MAX) : OUT_W'(-py);
        else
            res_y = (py > POS_MAX) ? POS_MAX[OUT_W-1:0] : py[OUT_W-1:0];
    end

    // ---------------- output register ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid <= 1'b0;
        else if (out_load)
            out_valid <= 1'b1;
        else if (out_ready)
            out_valid <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            force_x     <= $signed(res_x);
            force_y     <= $signed(res_y);
            inside_body <= inside_reg;
        end
    end

endmodule

@@ bench/tb_grid_disc_pairwise_force_sum.sv @@
`timescale 1ns / 100ps
// Testbench for grid_disc_pairwise_force_sum: drives grid cell queries, predicts
// the summed disc forces and checks every result in order.
// Depends on gdpfs_pkg and the grid_disc_pairwise_force_sum RTL.

typedef struct {
    logic signed [31:0] fx;
    logic signed [31:0] fy;
    logic               in_disc;
} disc_force_t;

// Holds the register copy, predicts the force for each accepted query and
// compares results against the oldest pending prediction.
class disc_force_board;
    logic [5:0]  radius;
    logic [31:0] gain;
    disc_force_t pending[$];
    int          errors;

    function new();
        radius = gdpfs_pkg::RADIUS_RST;
        gain   = gdpfs_pkg::GAIN_RST;
        errors = 0;
    endfunction

    function logic [31:0] scale_clamp(longint sum);
        longint unsigned mag;
        longint unsigned p;
        mag = (sum < 0) ? longint'(-sum) : longint'(sum);
        if (mag > 64'hFFFF_FFFF)
            mag = 64'hFFFF_FFFF;
        p = (mag * longint'(gain)) >> 16;
        if (sum < 0)
        begin
            if (p > 64'h8000_0000)
                p = 64'h8000_0000;
            return 32'(-longint'(p));
        end
        if (p > 64'h7FFF_FFFF)
            p = 64'h7FFF_FFFF;
        return 32'(p);
    endfunction

    function void note_query(logic [5:0] row, logic [5:0] col);
        longint      qr, qc, rr, u, v, dx, dy, rsq, sx, sy;
        disc_force_t e;
        qr = longint'(row) - 32;
        qc = longint'(col) - 32;
        rr = longint'(radius) * longint'(radius);
        sx = 0;
        sy = 0;
        for (int a = 0; a < 64; a++)
            for (int b = 0; b < 64; b++)
            begin
                u = a - 32;
                v = b - 32;
                if (u * u + v * v <= rr)
                begin
                    dx  = qr - u;
                    dy  = qc - v;
                    rsq = dx * dx + dy * dy;
                    if (rsq != 0)
                    begin
                        sx += (dx * 1048576) / rsq;
                        sy += (dy * 1048576) / rsq;
                    end
                end
            end
        e.fx      = scale_clamp(sx);
        e.fy      = scale_clamp(sy);
        e.in_disc = (qr * qr + qc * qc <= rr);
        pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] fx, logic [31:0] fy, logic ib);
        disc_force_t e;
        if (pending.size() == 0)
        begin
            $display("%0t: unexpected result fx=%h fy=%h inside=%b", $time, fx, fy, ib);
            errors++;
            return;
        end
        e = pending.pop_front();
        if (fx !== e.fx)
        begin
            $display("%0t: force_x expected %h actual %h", $time, e.fx, fx);
            errors++;
        end
        if (fy !== e.fy)
        begin
            $display("%0t: force_y expected %h actual %h", $time, e.fy, fy);
            errors++;
        end
        if (ib !== e.in_disc)
        begin
            $display("%0t: inside_body expected %b actual %b", $time, e.in_disc, ib);
            errors++;
        end
    endfunction
endclass

module tb_grid_disc_pairwise_force_sum;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            cfg_we = 1'b0;
    logic [gdpfs_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [gdpfs_pkg::CFG_DAT_W-1:0] cfg_data = '0;
    logic                            in_valid = 1'b0;
    logic                            in_ready;
    logic [gdpfs_pkg::IDX_W-1:0]     query_row = '0;
    logic [gdpfs_pkg::IDX_W-1:0]     query_col = '0;
    logic                            out_valid;
    logic                            out_ready = 1'b0;
    logic signed [31:0]              force_x;
    logic signed [31:0]              force_y;
    logic                            inside_body;

    disc_force_board board = new();
    int tx_idle_pct = 0;    // sender gap chance per item, percent
    int rx_idle_pct = 0;    // receiver stall chance per cycle, percent

    grid_disc_pairwise_force_sum dut (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result side: ready toggles at random, every accepted item is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
                board.check_result(force_x, force_y, inside_body);
            out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    task automatic write_reg(logic [gdpfs_pkg::CFG_IDX_W-1:0] idx, logic [31:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == gdpfs_pkg::REG_DISC_RADIUS)
            board.radius = val[5:0];
        else
            board.gain = val;
    endtask

    // Holds valid until the item is taken; an optional gap follows.
    task automatic send_query(logic [5:0] row, logic [5:0] col);
        in_valid  <= 1'b1;
        query_row <= row;
        query_col <= col;
        do
            @(posedge clk);
        while (!in_ready);
        board.note_query(row, col);
        if ($urandom_range(0, 99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    // Sender holds off until every result has arrived, then the engine settles.
    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    initial
    begin
        logic [5:0]  radii[7];
        logic [31:0] gains[7];
        radii = '{1, 32, 0, 63, 6'($urandom_range(1, 32)), 5, 6'($urandom)};
        gains = '{$urandom, 32'h0001_0000, 32'hFFFF_FFFF, 32'h0,
                  $urandom, 32'h0000_8000, $urandom};

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: corners, centre, disc edge at the reset radius of 16.
        send_query(0, 0);
        send_query(63, 63);
        send_query(0, 63);
        send_query(63, 0);
        send_query(32, 32);
        send_query(31, 32);
        send_query(32, 48);
        send_query(32, 49);
        send_query(48, 32);
        send_query(21, 42);
        drain();
        // zero radius: only the centre cell is a source
        write_reg(gdpfs_pkg::REG_DISC_RADIUS, 0);
        write_reg(gdpfs_pkg::REG_FORCE_GAIN, 32'hFFFF_FFFF);
        send_query(32, 32);
        send_query(33, 32);
        send_query(32, 31);
        send_query(0, 0);
        drain();
        // radius past the grid edge with a tiny gain
        write_reg(gdpfs_pkg::REG_DISC_RADIUS, 63);
        write_reg(gdpfs_pkg::REG_FORCE_GAIN, 32'h0000_0001);
        send_query(0, 0);
        send_query(63, 63);
        send_query(32, 32);
        drain();

        // Random phases, 126 items, idling per phase group.
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph < 3)
            begin
                tx_idle_pct = 10;
                rx_idle_pct = 47;
            end
            else if (ph < 5)
            begin
                tx_idle_pct = 47;
                rx_idle_pct = 10;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_reg(gdpfs_pkg::REG_DISC_RADIUS, 32'(radii[ph]));
            write_reg(gdpfs_pkg::REG_FORCE_GAIN, gains[ph]);
            for (int i = 0; i < 18; i++)
                send_query(6'($urandom), 6'($urandom));
            drain();
        end

        if (board.errors == 0)
            $display("grid_disc_pairwise_force_sum test passed");
        else
            $display("grid_disc_pairwise_force_sum test failed");
        $finish;
    end

    // Watchdog: several times the slowest correct run.
    initial
    begin
        #40_000_000;
        $display("grid_disc_pairwise_force_sum test failed");
        $finish;
    end
endmodule
